// ----- sv/tspt_pkg.sv -----
package tspt_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int MaxSteps     = 24;

    localparam logic signed [31:0] GainInvQ30 = 32'sd652032874;
    localparam logic signed [31:0] TwoPiQ28   = 32'sd1686629713;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx RegMajor = 3'd0;
    localparam t_reg_idx RegMinor = 3'd1;
    localparam t_reg_idx RegRowX  = 3'd2;
    localparam t_reg_idx RegRowY  = 3'd3;
    localparam t_reg_idx RegRowZ  = 3'd4;

    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] a;
        begin
            unique case (i)
                0: a = 34'sd536870912;
                1: a = 34'sd316933406;
                2: a = 34'sd167458907;
                3: a = 34'sd85004756;
                4: a = 34'sd42667331;
                5: a = 34'sd21354465;
                6: a = 34'sd10679838;
                7: a = 34'sd5340245;
                8: a = 34'sd2670163;
                9: a = 34'sd1335087;
                10: a = 34'sd667544;
                11: a = 34'sd333772;
                12: a = 34'sd166886;
                13: a = 34'sd83443;
                14: a = 34'sd41722;
                15: a = 34'sd20861;
                16: a = 34'sd10430;
                17: a = 34'sd5215;
                18: a = 34'sd2608;
                19: a = 34'sd1304;
                20: a = 34'sd652;
                21: a = 34'sd326;
                22: a = 34'sd163;
                23: a = 34'sd81;
                default: a = 34'sd0;
            endcase
            return a;
        end
    endfunction

endpackage

// ----- sv/torus_surface_point_tangent_eval_core.sv -----
// Throughput: one (u,v) word per cycle unless the output stalls.
// Every stage is a register in one pipeline: CORDIC input, CORDIC iterations, stages A to F.
// A stall on the output freezes the whole pipe; the output register holds its word.
// Reset (i_rst_n low, synchronous) clears all valid bits and loads the register
// defaults: R = 1.0, r = 0.25, identity transform with no translation.
module torus_surface_point_tangent_eval_core
    import tspt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // u_turn[15:0], v_turn[31:16]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [287:0] m_axis_tdata   // point_x,y,z, tan_u_x,y,z, tan_v_x,y,z; 32 bits each
);

    localparam int NS = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;

    // ---------------- configuration registers ----------------
    logic [15:0] r_major, r_minor;
    logic [63:0] r_row [3];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major  <= 16'd256;
            r_minor  <= 16'd64;
            r_row[0] <= 64'h0000_0000_0000_4000;
            r_row[1] <= 64'h0000_0000_4000_0000;
            r_row[2] <= 64'h0000_4000_0000_0000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegMajor: r_major  <= i_cfg_data[15:0];
                RegMinor: r_minor  <= i_cfg_data[15:0];
                RegRowX:  r_row[0] <= i_cfg_data;
                RegRowY:  r_row[1] <= i_cfg_data;
                RegRowZ:  r_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global enable: pipe advances unless output word is held
    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- CORDIC stages (two lanes: u and v) ----------------
    // stage k holds values after k iterations; x,y Q30 fit in 33 bits signed
    logic signed [32:0] r_cx [2][NS+1];
    logic signed [32:0] r_cy [2][NS+1];
    logic signed [33:0] r_cz [2][NS+1];
    logic [1:0]         r_cq [2][NS+1];
    logic [NS:0]        r_cv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= '0;
        else if (adv) r_cv <= {r_cv[NS-1:0], s_axis_tvalid};
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cx[l][0] <= 33'(GainInvQ30);
                r_cy[l][0] <= '0;
                r_cz[l][0] <= 34'($signed({1'b0, s_axis_tdata[16*l +: 14], 16'd0}));
                r_cq[l][0] <= s_axis_tdata[16*l+14 +: 2];
            end
        end
        for (genvar i = 0; i < NS; i++) begin : g_it
            logic signed [32:0] xs, ys;
            assign xs = r_cx[l][i] >>> i;
            assign ys = r_cy[l][i] >>> i;
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_cq[l][i+1] <= r_cq[l][i];
                    if (r_cz[l][i] >= 0) begin
                        r_cx[l][i+1] <= r_cx[l][i] - ys;
                        r_cy[l][i+1] <= r_cy[l][i] + xs;
                        r_cz[l][i+1] <= r_cz[l][i] - atan_turn(i);
                    end else begin
                        r_cx[l][i+1] <= r_cx[l][i] + ys;
                        r_cy[l][i+1] <= r_cy[l][i] - xs;
                        r_cz[l][i+1] <= r_cz[l][i] + atan_turn(i);
                    end
                end
            end
        end
    end

    // ---------------- stage A: round to Q16, quadrant map ----------------
    logic signed [19:0] r_cu, r_su, r_cvv, r_svv;
    logic               r_va;

    function automatic logic signed [19:0] rnd14(input logic signed [32:0] v);
        logic signed [33:0] t;
        begin
            t = 34'(v) + 34'sd8192;
            return 20'(t >>> 14);
        end
    endfunction

    logic signed [19:0] cr [2], sr [2], cc [2], ss [2];
    for (genvar l = 0; l < 2; l++) begin : g_q
        assign cr[l] = rnd14(r_cx[l][NS]);
        assign sr[l] = rnd14(r_cy[l][NS]);
        always_comb begin
            unique case (r_cq[l][NS])
                2'd0: begin cc[l] = cr[l];  ss[l] = sr[l];  end
                2'd1: begin cc[l] = -sr[l]; ss[l] = cr[l];  end
                2'd2: begin cc[l] = -cr[l]; ss[l] = -sr[l]; end
                default: begin cc[l] = sr[l]; ss[l] = -cr[l]; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (adv) r_va <= r_cv[NS];
        if (adv) begin
            r_cu <= cc[0]; r_su <= ss[0]; r_cvv <= cc[1]; r_svv <= ss[1];
        end
    end

    // ---------------- stage B: r*cos v, r*sin v, w ----------------
    logic signed [37:0] r_rc, r_rs;
    logic signed [41:0] r_w;
    logic signed [19:0] r_cub, r_sub;
    logic               r_vb;
    logic signed [37:0] rc_n, rs_n;
    assign rc_n = 38'($signed({1'b0, r_minor}) * r_cvv);
    assign rs_n = 38'($signed({1'b0, r_minor}) * r_svv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (adv) r_vb <= r_va;
        if (adv) begin
            r_rc  <= rc_n;
            r_rs  <= rs_n;
            r_w   <= $signed({2'b0, r_major, 24'd0}) >>> 8 ;
            r_cub <= r_cu;
            r_sub <= r_su;
        end
    end
    // w = R*2^16 + r*cos v
    logic signed [41:0] w_full;
    assign w_full = r_w + 42'(r_rc);

    // ---------------- stage C: products with trig, round to Q16 ----------------
    logic signed [63:0] pwc, pws, prc, prs;
    assign pwc = 64'(w_full) * 64'(r_cub);
    assign pws = 64'(w_full) * 64'(r_sub);
    assign prc = 64'(r_rs) * 64'(r_cub);
    assign prs = 64'(r_rs) * 64'(r_sub);

    function automatic logic signed [39:0] rsh(input logic signed [63:0] v,
                                               input int s);
        logic signed [63:0] t;
        begin
            t = v + (64'sd1 <<< (s - 1));
            return 40'(t >>> s);
        end
    endfunction

    logic signed [39:0] r_wc, r_ws, r_tvx0, r_tvy0, r_pz, r_tvz0;
    logic               r_vc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (adv) r_vc <= r_vb;
        if (adv) begin
            r_wc   <= rsh(pwc, 24);
            r_ws   <= rsh(pws, 24);
            r_tvx0 <= rsh(-prc, 24);
            r_tvy0 <= rsh(-prs, 24);
            r_pz   <= rsh(64'(r_rs), 8);
            r_tvz0 <= rsh(64'(r_rc), 8);
        end
    end
    // tu0 = round(-w*su) = -(ws) only if rounding symmetric -> compute exact
    logic signed [39:0] r_tux0;
    always_ff @(posedge i_clk) begin
        if (adv) r_tux0 <= rsh(-pws, 24);
    end

    // ---------------- stage D: 2pi scaling ----------------
    logic signed [39:0] r_p [3], r_tu [3], r_tv [3];
    logic               r_vd;
    function automatic logic signed [39:0] tp(input logic signed [39:0] v);
        return rsh(64'(v) * 64'(TwoPiQ28), 28);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else if (adv) r_vd <= r_vc;
        if (adv) begin
            r_p[0]  <= r_wc;  r_p[1] <= r_ws;  r_p[2] <= r_pz;
            r_tu[0] <= tp(r_tux0); r_tu[1] <= tp(r_wc); r_tu[2] <= '0;
            r_tv[0] <= tp(r_tvx0); r_tv[1] <= tp(r_tvy0); r_tv[2] <= tp(r_tvz0);
        end
    end

    // ---------------- stage E: coefficient products ----------------
    logic signed [57:0] r_m [3][3][3]; // [row][vector][component]
    logic signed [57:0] r_t [3];
    logic               r_ve;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ve <= 1'b0;
        else if (adv) r_ve <= r_vd;
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_m[k][0][c] <= 58'($signed(r_row[k][16*c +: 16]) * r_p[c]);
                    r_m[k][1][c] <= 58'($signed(r_row[k][16*c +: 16]) * r_tu[c]);
                    r_m[k][2][c] <= 58'($signed(r_row[k][16*c +: 16]) * r_tv[c]);
                end
                r_t[k] <= 58'($signed(r_row[k][63:48])) <<< 22;
            end
        end
    end

    // ---------------- stage F: sum, round, saturate; output register ----------------
    logic [287:0] n_out;
    always_comb begin
        logic signed [59:0] acc, rr;
        n_out = '0;
        for (int k = 0; k < 3; k++) begin
            for (int g = 0; g < 3; g++) begin
                acc = 60'(r_m[k][g][0]) + 60'(r_m[k][g][1]) + 60'(r_m[k][g][2]);
                if (g == 0) acc = acc + 60'(r_t[k]);
                rr = (acc + 60'sd2097152) >>> 22;
                if (rr > 60'sd2147483647)       n_out[32*(3*g+k) +: 32] = 32'h7FFF_FFFF;
                else if (rr < -60'sd2147483648) n_out[32*(3*g+k) +: 32] = 32'h8000_0000;
                else                            n_out[32*(3*g+k) +: 32] = rr[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (adv) m_axis_tvalid <= r_ve;
        if (adv) m_axis_tdata <= n_out;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

// Testbench for torus_surface_point_tangent_eval_core.
// A scoreboard class predicts the nine Q23.8 outputs for every accepted (u,v) word.
// Expected words are queued in order. Every output word is compared field by field.
// The run goes through several register settings, with radii and transform rows
// at their extremes and at random values.

class torus_scoreboard;
    localparam int Steps = (tspt_pkg::CORDIC_STEPS > 24) ? 24 : tspt_pkg::CORDIC_STEPS;
    localparam longint GainInv = 652032874;
    localparam longint TwoPi   = 1686629713;

    // atan(2^-i) in units of 2^-32 turn
    longint atan_tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    logic [15:0]  ring_r;
    logic [15:0]  tube_r;
    logic [63:0]  row[3];
    logic [287:0] expected_words[$];
    int           errors;
    int           results_seen;

    function new();
        ring_r  = 16'd256;
        tube_r  = 16'd64;
        row[0]  = 64'h4000;
        row[1]  = 64'h4000 << 16;
        row[2]  = 64'h4000 << 32;
        errors  = 0;
        results_seen = 0;
    endfunction

    function void set_reg(tspt_pkg::t_reg_idx idx, logic [63:0] data);
        case (idx)
            tspt_pkg::RegMajor: ring_r = data[15:0];
            tspt_pkg::RegMinor: tube_r = data[15:0];
            tspt_pkg::RegRowX:  row[0] = data;
            tspt_pkg::RegRowY:  row[1] = data;
            tspt_pkg::RegRowZ:  row[2] = data;
            default: ; // unused index, write dropped
        endcase
    endfunction

    // add half, then floor shift
    function longint rnd(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function void turn_trig(logic [15:0] t, output longint c, output longint s);
        longint x, y, z, xs, ys, cr, sr;
        x = GainInv;
        y = 0;
        z = longint'(t[13:0]) <<< 16;
        for (int i = 0; i < Steps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tbl[i];
            end else begin
                x += ys; y -= xs; z += atan_tbl[i];
            end
        end
        cr = rnd(x, 14);
        sr = rnd(y, 14);
        case (t[15:14])
            2'd0: begin c = cr;  s = sr;  end
            2'd1: begin c = -sr; s = cr;  end
            2'd2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    function logic [31:0] transform(logic [63:0] r, longint v[3], bit with_offset);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++)
            acc += longint'($signed(r[16*k +: 16])) * v[k];
        if (with_offset)
            acc += longint'($signed(r[63:48])) <<< 22;
        acc = rnd(acc, 22);
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function void note_uv(logic [15:0] u, logic [15:0] v);
        longint cu, su, cv, sv, w, rs, rc;
        longint p[3], tu[3], tv[3];
        logic [287:0] word;
        turn_trig(u, cu, su);
        turn_trig(v, cv, sv);
        w  = (longint'(ring_r) <<< 16) + longint'(tube_r) * cv;
        rs = longint'(tube_r) * sv;
        rc = longint'(tube_r) * cv;
        p[0]  = rnd(w * cu, 24);
        p[1]  = rnd(w * su, 24);
        p[2]  = rnd(rs, 8);
        tu[0] = rnd(-w * su, 24);
        tu[1] = rnd(w * cu, 24);
        tu[2] = 0;               // u tangent has no z before transform
        tv[0] = rnd(-rs * cu, 24);
        tv[1] = rnd(-rs * su, 24);
        tv[2] = rnd(rc, 8);
        for (int k = 0; k < 3; k++) begin
            tu[k] = rnd(tu[k] * TwoPi, 28);
            tv[k] = rnd(tv[k] * TwoPi, 28);
        end
        for (int k = 0; k < 3; k++) begin
            word[32*k +: 32]       = transform(row[k], p, 1'b1);
            word[32*(3+k) +: 32]   = transform(row[k], tu, 1'b0);
            word[32*(6+k) +: 32]   = transform(row[k], tv, 1'b0);
        end
        expected_words = {expected_words, word};
    endfunction

    function void check_word(logic [287:0] got);
        string names[9] = '{"point_x", "point_y", "point_z", "tan_u_x", "tan_u_y",
                            "tan_u_z", "tan_v_x", "tan_v_y", "tan_v_z"};
        logic [287:0] exp_w;
        results_seen++;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: output word with nothing expected: %h", got);
            return;
        end
        exp_w = expected_words.pop_front();
        for (int k = 0; k < 9; k++) begin
            if (got[32*k +: 32] !== exp_w[32*k +: 32]) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: word %0d %s expected %0d got %0d", results_seen,
                             names[k], $signed(exp_w[32*k +: 32]),
                             $signed(got[32*k +: 32]));
            end
        end
    endfunction
endclass

module testbench;
    import tspt_pkg::*;

    localparam int Latency = CORDIC_STEPS + 8;
    localparam int CycleLimit = 300000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // u_turn[15:0], v_turn[31:16]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [287:0] m_axis_tdata;   // point xyz, tan_u xyz, tan_v xyz

    torus_scoreboard board;
    int  cycles;
    int  uv_accepted;
    int  reg_writes;
    bit  burst;                   // no idling on either side while set

    torus_surface_point_tangent_eval_core dut (.*);

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // input and output monitors; all drives are nonblocking, so these see pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            board.note_uv(s_axis_tdata[15:0], s_axis_tdata[31:16]);
            uv_accepted++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycles, board.expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stall before each word, none during bursts
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = burst ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_uv(logic [15:0] u, logic [15:0] v);
        int n;
        n = burst ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // sender stops, everything expected comes back, pipe given time to empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_words.size() != 0)
            @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, data);
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_all(logic [15:0] rr, logic [15:0] tr,
                            logic [63:0] rx, logic [63:0] ry, logic [63:0] rz);
        write_reg(RegMajor, {48'hDEAD_BEEF_0000, rr});   // upper bits must be dropped
        write_reg(RegMinor, {$urandom, 16'($urandom_range(0, 65535)), tr});
        write_reg(RegRowX, rx);
        write_reg(RegRowY, ry);
        write_reg(RegRowZ, rz);
    endtask

    task automatic random_uv(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0)
                burst = ($urandom_range(0, 3) == 0);
            send_uv(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
        burst = 1'b0;
    endtask

    function automatic logic [63:0] rand_row();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [15:0] corner[13][2] = '{
            '{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h4000, 16'h0000},
            '{16'h8000, 16'h0000}, '{16'hC000, 16'h0000}, '{16'h0000, 16'h4000},
            '{16'h0000, 16'h8000}, '{16'h0000, 16'hC000}, '{16'h2000, 16'h2000},
            '{16'h0001, 16'hFFFF}, '{16'hFFFF, 16'h0001}, '{16'h3FFF, 16'h4000},
            '{16'hC000, 16'h7FFF}};
        board = new();
        cycles = 0;
        uv_accepted = 0;
        reg_writes = 0;
        burst = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= RegMajor;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults, corner angles (quadrant edges, wrap-around)
        foreach (corner[i])
            send_uv(corner[i][0], corner[i][1]);
        drain();

        // writes to unused indexes must leave the registers alone
        write_reg(t_reg_idx'(5), 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(t_reg_idx'(6), 64'h8000_8000_8000_8000);
        write_reg(t_reg_idx'(7), rand_row());
        for (int i = 0; i < 4; i++)
            send_uv(corner[i][0], corner[i][1]);
        random_uv(150);
        drain();

        // largest radii, full positive coefficients and offset: saturation high
        load_all(16'hFFFF, 16'hFFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        foreach (corner[i])
            send_uv(corner[i][0], corner[i][1]);
        random_uv(120);
        drain();

        // most negative coefficients and offset
        load_all(16'hFFFF, 16'h0000, 64'h8000_8000_8000_8000,
                 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        random_uv(120);
        drain();

        // zero radii, zero transform
        load_all(16'h0000, 16'h0000, 64'h0, 64'h0, 64'h0);
        random_uv(40);
        drain();

        // random settings; drain between phases also pauses the sender fully
        for (int ph = 0; ph < 6; ph++) begin
            load_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     rand_row(), rand_row(), rand_row());
            random_uv(110);
            drain();
        end

        // back to reset values, modest ring
        load_all(16'h0100, 16'h0040, 64'h4000, 64'h4000 << 16, 64'h4000 << 32);
        random_uv(60);
        drain();

        $display("Covered %0d (u,v) words and %0d register writes over 11 settings,",
                 uv_accepted, reg_writes);
        $display("including saturation, zero radii and ignored register indexes.");
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
